// File: rtl/odo_pkg.sv
`timescale 1ns / 1ps
package odo_pkg;

  localparam int PosBitsDef   = 48;
  localparam int AngleBitsDef = 32;

  localparam int CordicIters = 30;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;
  localparam logic signed [33:0] InvTwoPi   = 34'sd683565276;

  localparam logic [23:0] LeftStepRst  = 24'd809826;
  localparam logic [23:0] RightStepRst = 24'd812415;
  localparam logic [15:0] WheelBaseRst = 16'd541;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_LEFT_STEP  = 2'd0,
    REG_RIGHT_STEP = 2'd1,
    REG_WHEEL_BASE = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_PMUL, ST_PREP, ST_DIV, ST_HEAD,
    ST_CORDIC, ST_MULX, ST_MULY, ST_ADDY, ST_DONE
  } back_state_e;

  typedef struct packed {
    logic              first;
    logic signed [7:0] left_delta;
    logic signed [7:0] right_delta;
  } item_t;

  typedef struct packed {
    logic [23:0] left_step;
    logic [23:0] right_step;
    logic [15:0] wheel_base;
  } cfg_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
    logic signed [47:0] distance;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
  } result_t;

  function automatic logic signed [32:0] atan_entry(input logic [4:0] i);
    logic signed [32:0] r;
    case (i)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Differential-drive wheel odometry. Encoder deltas enter through a two-entry
// queue and one result comes out per transaction through a one-entry output
// register. The first transaction after reset only marks the start and
// returns valid_res_o low with the (zero) state. Each later transaction runs
// through the update engine: a bit-serial heading divider over an NW-bit
// numerator, where NW = ANGLE_BITS + 15, then a CORDIC rotator, with one
// shared multiplier for the heading scale and both position products. A zero
// wheel base skips the divider.
module differential_drive_odometry #(
  parameter int POS_BITS   = odo_pkg::PosBitsDef,
  parameter int ANGLE_BITS = odo_pkg::AngleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  left_delta_i,
  input  logic signed [7:0]  right_delta_i,
  output logic               empty,
  input  logic               pop,
  output logic               valid_res_o,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [47:0] distance_o,
  output logic signed [31:0] left_total_o,
  output logic signed [31:0] right_total_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);

  odo_pkg::cfg_t    cfg_q;
  odo_pkg::item_t   q_wdata, q_rdata;
  odo_pkg::result_t res;
  logic q_wr, q_full, q_rd, q_empty, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_step  <= odo_pkg::LeftStepRst;
      cfg_q.right_step <= odo_pkg::RightStepRst;
      cfg_q.wheel_base <= odo_pkg::WheelBaseRst;
    end else if (cfg_we_i) begin
      unique case (odo_pkg::reg_idx_e'(cfg_idx_i))
        odo_pkg::REG_LEFT_STEP:  cfg_q.left_step  <= cfg_data_i;
        odo_pkg::REG_RIGHT_STEP: cfg_q.right_step <= cfg_data_i;
        odo_pkg::REG_WHEEL_BASE: cfg_q.wheel_base <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  odo_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .left_delta_i, .right_delta_i,
    .q_wr_o(q_wr), .q_data_o(q_wdata), .q_full_i(q_full)
  );

  odo_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(q_wr), .wr_data_i(q_wdata), .full_o(q_full),
    .rd_i(q_rd), .rd_data_o(q_rdata), .empty_o(q_empty)
  );

  odo_back #(.POS_BITS(POS_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_empty_i(q_empty), .q_data_i(q_rdata), .q_rd_o(q_rd),
    .res_valid_o(res_valid), .res_o(res), .res_pop_i(pop)
  );

  assign empty         = !res_valid;
  assign valid_res_o   = res.valid_res;
  assign pos_x_o       = res.pos_x;
  assign pos_y_o       = res.pos_y;
  assign heading_o     = res.heading;
  assign distance_o    = res.distance;
  assign left_total_o  = res.left_total;
  assign right_total_o = res.right_total;

endmodule

// File: rtl/odo_queue.sv
`timescale 1ns / 1ps
module odo_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  odo_pkg::item_t  wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output odo_pkg::item_t  rd_data_o,
  output logic            empty_o
);

  localparam int PtrW = $clog2(odo_pkg::QueueDepth);

  odo_pkg::item_t mem_q [odo_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o    = (count_q == (PtrW+1)'(odo_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_i && !rd_i) count_q <= count_q + 1'b1;
      else if (rd_i && !wr_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// File: rtl/odo_front.sv
`timescale 1ns / 1ps
module odo_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic signed [7:0] left_delta_i,
  input  logic signed [7:0] right_delta_i,
  output logic              q_wr_o,
  output odo_pkg::item_t    q_data_o,
  input  logic              q_full_i
);

  logic first_seen_q;

  assign full   = q_full_i;
  assign q_wr_o = push && !q_full_i;

  // The first transaction after reset only marks the start.
  always_comb begin
    q_data_o.first       = !first_seen_q;
    q_data_o.left_delta  = left_delta_i;
    q_data_o.right_delta = right_delta_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seen_q <= 1'b0;
    end else if (q_wr_o) begin
      first_seen_q <= 1'b1;
    end
  end

endmodule

// File: rtl/odo_back.sv
`timescale 1ns / 1ps
module odo_back #(
  parameter int POS_BITS   = odo_pkg::PosBitsDef,
  parameter int ANGLE_BITS = odo_pkg::AngleBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  odo_pkg::cfg_t    cfg_i,
  input  logic             q_empty_i,
  input  odo_pkg::item_t   q_data_i,
  output logic             q_rd_o,
  output logic             res_valid_o,
  output odo_pkg::result_t res_o,
  input  logic             res_pop_i
);

  localparam int K   = 48 - ANGLE_BITS;
  localparam int NW  = 15 + ANGLE_BITS;
  localparam int CW  = $clog2(NW);
  localparam int PB  = POS_BITS;

  function automatic logic signed [PB-1:0] sat_add(input logic signed [PB-1:0] a,
                                                   input logic signed [PB-1:0] b);
    logic signed [PB:0] s;
    logic signed [PB-1:0] r;
    s = {a[PB-1], a} + {b[PB-1], b};
    if (s[PB] != s[PB-1]) r = s[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    else r = s[PB-1:0];
    return r;
  endfunction

  odo_pkg::back_state_e state_q, state_d;

  // Odometry state.
  logic signed [31:0]         lsum_q, rsum_q;
  logic signed [PB-1:0]       dist_q, posx_q, posy_q;
  logic [ANGLE_BITS-1:0]      head_q;

  // Working registers.
  logic signed [7:0]          ld_q, rd_q;
  logic signed [33:0]         sum_q, diff_q;
  logic signed [66:0]         prod_q;
  logic                       neg_q;
  logic [NW-1:0]              num_q;
  logic [15:0]                rem_q;
  logic [ANGLE_BITS-1:0]      quo_q;
  logic [CW-1:0]              step_q;
  logic signed [32:0]         x_q, y_q, z_q;
  logic [1:0]                 quad_q;
  logic                       out_valid_q;
  odo_pkg::result_t           out_q;
  // Tracks whether the item now finishing went through the update path.
  logic                       upd_q;

  // Combinational helpers.
  logic signed [32:0] tl, tr;
  logic signed [33:0] ma, mb;
  logic signed [66:0] prod_d;
  logic [66:0]        mag;
  logic [66:0]        nfull;
  logic [16:0]        r2;
  logic               qbit;
  logic [ANGLE_BITS-1:0] h_new;
  logic [31:0]        a32, u;
  logic [31:0]        a_off;
  logic [1:0]         qd;
  logic signed [32:0] sx, sy, at;
  logic signed [32:0] cs, sn;
  logic signed [34:0] dsum;
  logic signed [24:0] dstep;
  logic signed [66:0] rnd;
  logic signed [27:0] dpos;
  logic               out_free;

  assign tl = 33'(ld_q) * 33'($signed({1'b0, cfg_i.left_step}));
  assign tr = 33'(rd_q) * 33'($signed({1'b0, cfg_i.right_step}));

  always_comb begin
    unique case (quad_q)
      2'd0: begin cs = x_q;  sn = y_q;  end
      2'd1: begin cs = -y_q; sn = x_q;  end
      2'd2: begin cs = -x_q; sn = -y_q; end
      default: begin cs = y_q; sn = -x_q; end
    endcase
  end

  // One shared multiplier for the heading scale and both position products.
  always_comb begin
    ma = sum_q;
    mb = 34'(cs);
    case (state_q)
      odo_pkg::ST_PMUL: begin ma = diff_q; mb = odo_pkg::InvTwoPi; end
      odo_pkg::ST_MULY: mb = 34'(sn);
      default: ;
    endcase
  end
  assign prod_d = 67'(ma) * 67'(mb);

  assign mag   = prod_q[66] ? 67'(-prod_q) : 67'(prod_q);
  assign nfull = (mag + (67'(cfg_i.wheel_base) << (K - 1))) >> K;

  assign r2   = {rem_q, num_q[NW-1]};
  assign qbit = (r2 >= {1'b0, cfg_i.wheel_base});

  assign h_new = neg_q ? head_q - quo_q : head_q + quo_q;
  assign a32   = 32'(h_new) << (32 - ANGLE_BITS);
  assign a_off = a32 + 32'h4000_0000;
  assign qd    = a_off[31:30];
  assign u     = a32 - {qd, 30'b0};

  assign sx = x_q >>> step_q;
  assign sy = y_q >>> step_q;
  assign at = odo_pkg::atan_entry(step_q[4:0]);

  assign dsum  = 35'(sum_q) + 35'sd256;
  assign dstep = 25'(dsum >>> 9);
  assign rnd   = prod_q + (67'sd1 <<< 38);
  assign dpos  = 28'(rnd >>> 39);

  assign out_free    = !out_valid_q || res_pop_i;
  assign q_rd_o      = (state_q == odo_pkg::ST_IDLE) && !q_empty_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      odo_pkg::ST_IDLE: begin
        if (!q_empty_i) state_d = q_data_i.first ? odo_pkg::ST_DONE : odo_pkg::ST_SCALE;
      end
      odo_pkg::ST_SCALE: state_d = odo_pkg::ST_PMUL;
      odo_pkg::ST_PMUL:  state_d = odo_pkg::ST_PREP;
      odo_pkg::ST_PREP: begin
        state_d = (cfg_i.wheel_base == '0) ? odo_pkg::ST_HEAD : odo_pkg::ST_DIV;
      end
      odo_pkg::ST_DIV: if (step_q == CW'(NW - 1)) state_d = odo_pkg::ST_HEAD;
      odo_pkg::ST_HEAD: state_d = odo_pkg::ST_CORDIC;
      odo_pkg::ST_CORDIC: begin
        if (step_q == CW'(odo_pkg::CordicIters - 1)) state_d = odo_pkg::ST_MULX;
      end
      odo_pkg::ST_MULX: state_d = odo_pkg::ST_MULY;
      odo_pkg::ST_MULY: state_d = odo_pkg::ST_ADDY;
      odo_pkg::ST_ADDY: state_d = odo_pkg::ST_DONE;
      odo_pkg::ST_DONE: if (out_free) state_d = odo_pkg::ST_IDLE;
      default: state_d = odo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= odo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      lsum_q      <= '0;
      rsum_q      <= '0;
      dist_q      <= '0;
      posx_q      <= '0;
      posy_q      <= '0;
      head_q      <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == odo_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
      case (state_q)
        odo_pkg::ST_SCALE: begin
          lsum_q <= lsum_q + 32'(ld_q);
          rsum_q <= rsum_q + 32'(rd_q);
        end
        odo_pkg::ST_PREP: begin
          dist_q <= sat_add(dist_q, PB'(dstep));
          step_q <= '0;
        end
        odo_pkg::ST_DIV: step_q <= (step_q == CW'(NW - 1)) ? '0 : step_q + 1'b1;
        odo_pkg::ST_HEAD: begin
          head_q <= h_new;
          step_q <= '0;
        end
        odo_pkg::ST_CORDIC: step_q <= step_q + 1'b1;
        odo_pkg::ST_MULY:   posx_q <= sat_add(posx_q, PB'(dpos));
        odo_pkg::ST_ADDY:   posy_q <= sat_add(posy_q, PB'(-dpos));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      odo_pkg::ST_IDLE: begin
        ld_q <= q_data_i.left_delta;
        rd_q <= q_data_i.right_delta;
        neg_q <= 1'b0;
        quo_q <= '0;
      end
      odo_pkg::ST_SCALE: begin
        sum_q  <= 34'(tl) + 34'(tr);
        diff_q <= 34'(tr) - 34'(tl);
      end
      odo_pkg::ST_PMUL: prod_q <= prod_d;
      odo_pkg::ST_PREP: begin
        neg_q <= prod_q[66];
        num_q <= nfull[NW-1:0];
        rem_q <= '0;
        quo_q <= '0;
      end
      odo_pkg::ST_DIV: begin
        rem_q <= qbit ? 16'(r2 - {1'b0, cfg_i.wheel_base}) : r2[15:0];
        quo_q <= {quo_q[ANGLE_BITS-2:0], qbit};
        num_q <= num_q << 1;
      end
      odo_pkg::ST_HEAD: begin
        quad_q <= qd;
        x_q    <= odo_pkg::CordicGain;
        y_q    <= '0;
        z_q    <= 33'($signed(u));
      end
      odo_pkg::ST_CORDIC: begin
        if (!z_q[32]) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + at;
        end
      end
      odo_pkg::ST_MULX, odo_pkg::ST_MULY: prod_q <= prod_d;
      odo_pkg::ST_DONE: begin
        if (out_free) begin
          out_q.valid_res   <= upd_q;
          out_q.pos_x       <= 48'(posx_q);
          out_q.pos_y       <= 48'(posy_q);
          out_q.heading     <= 32'(head_q);
          out_q.distance    <= 48'(dist_q);
          out_q.left_total  <= lsum_q;
          out_q.right_total <= rsum_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) upd_q <= 1'b0;
    else if (state_q == odo_pkg::ST_IDLE && !q_empty_i) upd_q <= !q_data_i.first;
  end

endmodule

// File: rtl/odo_checker.sv
`timescale 1ns / 1ps
module odo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic               valid_res_o,
  input logic signed [47:0] pos_x_o,
  input logic [31:0]        heading_o,
  input logic signed [47:0] distance_o,
  input logic signed [31:0] left_total_o
);

  logic seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seen_q <= 1'b0;
    else if (pop && !empty) seen_q <= 1'b1;
  end

  // Only the first result after reset is the start mark.
  a_first_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !seen_q |-> !valid_res_o) else $error("start mark not flagged");

  a_later_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && seen_q |-> valid_res_o) else $error("update result not flagged");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !valid_res_o |-> pos_x_o == 48'd0 && distance_o == 48'd0 &&
    heading_o == 32'd0 && left_total_o == 32'd0) else $error("start mark state not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pos_x_o) && $stable(heading_o))
    else $error("waiting result changed");

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (.*);
